[hdl/cvr_pkg.sv]
// Shared types, constants and arithmetic helpers for the circular CORDIC block.
// Depends on nothing; every other file of the block refers to it by scoped name.
`timescale 1ns / 1ps

package cvr_pkg;

  // Field widths of the channel payloads
  localparam int XY_IN_W = 17;
  localparam int Z_IN_W  = 19;
  localparam int OUT_W   = 19;

  // Working width: holds the pre-turned vector and the full micro-rotation growth
  localparam int DW = 22;

  // Fixed point format of the angle constants
  localparam int FRAC_BITS  = 16;
  localparam int TABLE_FRAC = 30;
  localparam int TABLE_LEN  = 20;
  localparam int RND_SHIFT  = TABLE_FRAC - FRAC_BITS;

  localparam logic [63:0] RND_HALF = 64'd1 << (RND_SHIFT - 1);

  // pi and the rotation pre-turn threshold (1.742 rad), rounded to FRAC_BITS
  localparam logic signed [DW-1:0] PI_FX  = DW'((64'd3373259426 + RND_HALF) >> RND_SHIFT);
  localparam logic signed [DW-1:0] THR_FX =
    DW'(((64'd1742 << FRAC_BITS) + 64'd500) / 64'd1000);

  // atan(2^-j) in units of 2^-30, truncated
  localparam logic [31:0] ATAN_Q30 [TABLE_LEN] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
    32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
    32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
    32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF
  };

  // One vector in flight through the pipeline
  typedef struct packed {
    logic                 mode;   // 1 rotation, 0 vectoring
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] z;
  } cvr_vec_t;

  // Table angle for micro-rotation j, rounded half up to FRAC_BITS
  function automatic logic signed [DW-1:0] atan_angle(input logic [4:0] j);
    logic [63:0] t;
    t = 64'd0;
    if (j < 5'(TABLE_LEN)) begin
      t = ({32'd0, ATAN_Q30[j]} + RND_HALF) >> RND_SHIFT;
    end
    return DW'(t);
  endfunction

endpackage

[hdl/cvr_in_if.sv]
// Input channel of the CORDIC block: valid/ready handshake with mode, x, y, z.
// Depends on cvr_pkg for the field widths.
`timescale 1ns / 1ps

interface cvr_in_if;
  logic                                valid;
  logic                                ready;
  logic                                mode;
  logic signed [cvr_pkg::XY_IN_W-1:0]  x_in;
  logic signed [cvr_pkg::XY_IN_W-1:0]  y_in;
  logic signed [cvr_pkg::Z_IN_W-1:0]   z_in;

  modport source (output valid, mode, x_in, y_in, z_in, input ready);
  modport sink   (input valid, mode, x_in, y_in, z_in, output ready);
endinterface

[hdl/cvr_out_if.sv]
// Result channel of the CORDIC block: valid/ready handshake with x, y, z.
// Depends on cvr_pkg for the field widths.
`timescale 1ns / 1ps

interface cvr_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [cvr_pkg::OUT_W-1:0]  x_out;
  logic signed [cvr_pkg::OUT_W-1:0]  y_out;
  logic signed [cvr_pkg::OUT_W-1:0]  z_out;

  modport source (output valid, x_out, y_out, z_out, input ready);
  modport sink   (input valid, x_out, y_out, z_out, output ready);
endinterface

[hdl/cvr_micro.sv]
// One registered circular CORDIC micro-rotation with a fixed shift.
// Depends on cvr_pkg for the vector type and the arctangent table.
`timescale 1ns / 1ps

module cvr_micro #(
  parameter int SHIFT = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             valid_in,
  input  cvr_pkg::cvr_vec_t vec_in,
  output logic             valid_out,
  output cvr_pkg::cvr_vec_t vec_out
);

  localparam logic signed [cvr_pkg::DW-1:0] ANGLE = cvr_pkg::atan_angle(5'(SHIFT));

  logic                               valid_r;
  cvr_pkg::cvr_vec_t                  vec_r;
  cvr_pkg::cvr_vec_t                  vec_nxt;
  logic signed [cvr_pkg::DW-1:0]      xs;
  logic signed [cvr_pkg::DW-1:0]      ys;
  logic                               ccw;

  always_comb begin
    xs  = vec_in.x >>> SHIFT;
    ys  = vec_in.y >>> SHIFT;
    // rotation chases z to zero, vectoring chases y to zero
    ccw = vec_in.mode ? ~vec_in.z[cvr_pkg::DW-1] : vec_in.y[cvr_pkg::DW-1];
    vec_nxt.mode = vec_in.mode;
    if (ccw) begin
      vec_nxt.x = vec_in.x - ys;
      vec_nxt.y = vec_in.y + xs;
      vec_nxt.z = vec_in.z - ANGLE;
    end else begin
      vec_nxt.x = vec_in.x + ys;
      vec_nxt.y = vec_in.y - xs;
      vec_nxt.z = vec_in.z + ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r <= vec_nxt;
    end
  end

  assign valid_out = valid_r;
  assign vec_out   = vec_r;

endmodule

[hdl/cordic_rotate_vector.sv]
// Circular CORDIC, rotation and vectoring mode, fully pipelined.
// Throughput: one transaction per cycle; a stalled result holds only the stages behind it.
// Reset (rst_n low, synchronous) clears every stage valid bit; payload is not reset.
// Depends on cvr_pkg, cvr_in_if, cvr_out_if and cvr_micro.
`timescale 1ns / 1ps

module cordic_rotate_vector #(
  parameter int ITERATIONS = 12
) (
  input  logic       clk,
  input  logic       rst_n,
  cvr_in_if.sink     in_ch,
  cvr_out_if.source  out_ch
);

  localparam int DW    = cvr_pkg::DW;
  localparam int OW    = cvr_pkg::OUT_W;
  localparam int XW    = cvr_pkg::XY_IN_W;
  localparam int ZW    = cvr_pkg::Z_IN_W;
  // pre-turn stage, one stage per micro-rotation, gain stage, output register
  localparam int NST   = ITERATIONS + 3;
  localparam int G_IDX = ITERATIONS + 1;
  localparam int O_IDX = ITERATIONS + 2;

  localparam logic signed [DW:0] SAT_HI = (DW+1)'((64'd1 << (OW - 1)) - 64'd1);
  localparam logic signed [DW:0] SAT_LO = -SAT_HI - (DW+1)'(1);

  // Gain compensation: 1/2 + 1/8 + 1/64 - 1/32, arithmetic shifts
  function automatic logic signed [DW:0] gain_fix(input logic signed [DW-1:0] v);
    logic signed [DW:0] e;
    e = {v[DW-1], v};
    return (e >>> 1) + (e >>> 3) + (e >>> 6) - (e >>> 5);
  endfunction

  function automatic logic signed [OW-1:0] sat_out(input logic signed [DW:0] v);
    logic signed [DW:0] c;
    c = v;
    if (v > SAT_HI) begin
      c = SAT_HI;
    end else if (v < SAT_LO) begin
      c = SAT_LO;
    end
    return c[OW-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Flow control: a stage may load when it or any stage ahead of it is empty,
  // or when the result is being taken. Bubbles collapse; nothing is dropped.
  // ---------------------------------------------------------------------------
  logic [NST-1:0] vld;
  logic [NST-1:0] rdy;

  genvar k;
  generate
    for (k = 0; k < NST; k++) begin : g_rdy
      assign rdy[k] = out_ch.ready | ~(&vld[NST-1:k]);
    end
  endgenerate

  assign in_ch.ready = rdy[0];

  // ---------------------------------------------------------------------------
  // Stage 0: quadrant pre-turn into the range the micro-rotations converge on
  // ---------------------------------------------------------------------------
  logic              pre_v_r;
  cvr_pkg::cvr_vec_t pre_r;
  cvr_pkg::cvr_vec_t pre_nxt;
  logic signed [DW-1:0] x0;
  logic signed [DW-1:0] y0;
  logic signed [DW-1:0] z0;

  always_comb begin
    x0 = {{(DW-XW){in_ch.x_in[XW-1]}}, in_ch.x_in};
    y0 = {{(DW-XW){in_ch.y_in[XW-1]}}, in_ch.y_in};
    z0 = {{(DW-ZW){in_ch.z_in[ZW-1]}}, in_ch.z_in};
    pre_nxt.mode = in_ch.mode;
    pre_nxt.x    = x0;
    pre_nxt.y    = y0;
    pre_nxt.z    = z0;
    if (in_ch.mode) begin
      // rotation: fold angles beyond the threshold back by half a turn
      if (z0 > cvr_pkg::THR_FX) begin
        pre_nxt.x = -x0;
        pre_nxt.y = -y0;
        pre_nxt.z = z0 - cvr_pkg::PI_FX;
      end else if (z0 < -cvr_pkg::THR_FX) begin
        pre_nxt.x = -x0;
        pre_nxt.y = -y0;
        pre_nxt.z = z0 + cvr_pkg::PI_FX;
      end
    end else if (x0[DW-1]) begin
      // vectoring: mirror a left-half-plane vector, keep z on the side of y
      pre_nxt.x = -x0;
      pre_nxt.y = -y0;
      pre_nxt.z = y0[DW-1] ? (z0 - cvr_pkg::PI_FX) : (z0 + cvr_pkg::PI_FX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_v_r <= 1'b0;
    end else if (rdy[0]) begin
      pre_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      pre_r <= pre_nxt;
    end
  end

  assign vld[0] = pre_v_r;

  // ---------------------------------------------------------------------------
  // Stages 1..ITERATIONS: one micro-rotation each, shift j in stage j+1
  // ---------------------------------------------------------------------------
  cvr_pkg::cvr_vec_t mic [ITERATIONS+1];

  assign mic[0] = pre_r;

  genvar j;
  generate
    for (j = 0; j < ITERATIONS; j++) begin : g_mic
      cvr_micro #(
        .SHIFT (j)
      ) u_mic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (rdy[j+1]),
        .valid_in  (vld[j]),
        .vec_in    (mic[j]),
        .valid_out (vld[j+1]),
        .vec_out   (mic[j+1])
      );
    end
  endgenerate

  // ---------------------------------------------------------------------------
  // Gain stage: scale x and y; z passes untouched
  // ---------------------------------------------------------------------------
  logic              gain_v_r;
  logic signed [DW:0] gx_r;
  logic signed [DW:0] gy_r;
  logic signed [DW:0] gz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_v_r <= 1'b0;
    end else if (rdy[G_IDX]) begin
      gain_v_r <= vld[ITERATIONS];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[G_IDX]) begin
      gx_r <= gain_fix(mic[ITERATIONS].x);
      gy_r <= gain_fix(mic[ITERATIONS].y);
      gz_r <= {mic[ITERATIONS].z[DW-1], mic[ITERATIONS].z};
    end
  end

  assign vld[G_IDX] = gain_v_r;

  // ---------------------------------------------------------------------------
  // Output register: saturate to the result width and hold until taken
  // ---------------------------------------------------------------------------
  logic              out_v_r;
  logic signed [OW-1:0] ox_r;
  logic signed [OW-1:0] oy_r;
  logic signed [OW-1:0] oz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (rdy[O_IDX]) begin
      out_v_r <= gain_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[O_IDX]) begin
      ox_r <= sat_out(gx_r);
      oy_r <= sat_out(gy_r);
      oz_r <= sat_out(gz_r);
    end
  end

  assign vld[O_IDX] = out_v_r;

  assign out_ch.valid = out_v_r;
  assign out_ch.x_out = ox_r;
  assign out_ch.y_out = oy_r;
  assign out_ch.z_out = oz_r;

endmodule

[hdl/cvr_checker.sv]
// Port-level checks for cordic_rotate_vector, attached by the bind at the end.
// Depends on cvr_pkg for the result width.
`timescale 1ns / 1ps

module cvr_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [cvr_pkg::OUT_W-1:0]     out_x,
  input logic [cvr_pkg::OUT_W-1:0]     out_y,
  input logic [cvr_pkg::OUT_W-1:0]     out_z
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // handshake controls stay known out of reset
  a_ctrl_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown({in_valid, out_ready}))
    else $error("handshake control unknown");

  // an empty output register never back-pressures the input
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // a sink that takes every result never stalls the input
  a_flow_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while results drain");

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z))
    else $error("stalled result changed or vanished");

endmodule

bind cordic_rotate_vector cvr_checker u_cvr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_x     (out_ch.x_out),
  .out_y     (out_ch.y_out),
  .out_z     (out_ch.z_out)
);
